// ===== rtl/ixa_pkg.sv =====
package ixa_pkg;

    localparam int HEAP_DEPTH_DEF = 1024;
    localparam int IDX_W          = 10;
    localparam int ST_W           = 2;
    localparam int CNT_W          = 11;
    localparam int OUT_DEPTH      = 3;
    localparam int OUT_PTR_W      = $clog2(OUT_DEPTH);
    localparam int OUT_FILL_W     = $clog2(OUT_DEPTH + 1);

    localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 11'd1024;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_DUP       = 2'd2
    } status_t;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        status_t          status;
        logic [CNT_W-1:0] used_count;
    } result_t;

endpackage

// ===== rtl/ixa_if.sv =====
interface ixa_req_if;
    import ixa_pkg::*;

    logic             valid;
    logic             ready;
    logic             mode;
    logic [IDX_W-1:0] free_index;

    modport source (output valid, output mode, output free_index, input ready);
    modport sink (input valid, input mode, input free_index, output ready);
endinterface

interface ixa_res_if;
    import ixa_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] used_count;

    modport source (output valid, output index, output status, output used_count, input ready);
    modport sink (input valid, input index, input status, input used_count, output ready);
endinterface

interface ixa_cfg_if;
    import ixa_pkg::*;

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] max_entries;

    modport source (output valid, output max_entries, input ready);
    modport sink (input valid, input max_entries, output ready);
endinterface

// ===== rtl/ixa_ram.sv =====
module ixa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

// ===== rtl/ixa_out_fifo.sv =====
module ixa_out_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_valid,
    input  ixa_pkg::result_t               wr_data,
    output logic                           rd_valid,
    input  logic                           rd_ready,
    output ixa_pkg::result_t               rd_data,
    output logic [ixa_pkg::OUT_FILL_W-1:0] fill
);
    import ixa_pkg::*;

    localparam logic [OUT_PTR_W-1:0] LAST = OUT_PTR_W'(OUT_DEPTH - 1);

    result_t                mem_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OUT_FILL_W-1:0]  fill_reg, fill_next;
    logic                   rd_fire;

    assign rd_valid = (fill_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign fill     = fill_reg;
    assign rd_fire  = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (wr_valid)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_valid && !rd_fire)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!wr_valid && rd_fire)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_valid)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end
endmodule

// ===== rtl/ixa_core.sv =====
module ixa_core #(
    parameter int HEAP_DEPTH = ixa_pkg::HEAP_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          acc,
    input  logic                          in_mode,
    input  logic [ixa_pkg::IDX_W-1:0]     in_fidx,
    input  logic [ixa_pkg::CNT_W-1:0]     max_entries,
    input  logic                          clr_busy,
    input  logic [$clog2(HEAP_DEPTH)-1:0] clr_addr,
    output logic                          res_valid,
    output ixa_pkg::result_t              res
);
    import ixa_pkg::*;

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int QW = AW + 1;
    localparam int UW = (QW > CNT_W) ? QW : CNT_W;
    localparam logic [AW-1:0] LAST = AW'(HEAP_DEPTH - 1);
    localparam logic [QW-1:0] FULL = QW'(HEAP_DEPTH);

    logic             s1_valid_reg;
    logic             s1_mode_reg;
    logic [IDX_W-1:0] s1_fidx_reg;
    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    tail_reg, tail_next;
    logic [QW-1:0]    count_reg, count_next;
    logic [CNT_W-1:0] fresh_reg, fresh_next;
    logic             q_fwd_reg, q_fwd_next;
    logic [IDX_W-1:0] q_fwd_data_reg;
    logic             m_fwd_reg, m_fwd_next;
    logic             m_fwd_data_reg;

    logic [IDX_W-1:0] q_rdata, q_head;
    logic             m_rdata, marked;
    logic             m_we, m_wdata;
    logic [AW-1:0]    m_waddr, m_raddr;
    logic [CNT_W-1:0] limit;
    logic             in_heap, is_alloc, pop, grant, exhaust, push, dup;
    logic [UW-1:0]    fresh_u, count_u;
    logic [CNT_W-1:0] used;

    always_comb
    begin
        q_head   = q_fwd_reg ? q_fwd_data_reg : q_rdata;
        marked   = m_fwd_reg ? m_fwd_data_reg : m_rdata;
        limit    = (32'(max_entries) > HEAP_DEPTH) ? CNT_W'(HEAP_DEPTH) : max_entries;
        in_heap  = (32'(s1_fidx_reg) < HEAP_DEPTH);
        is_alloc = s1_valid_reg && (s1_mode_reg == MODE_ALLOC);
        pop      = is_alloc && (count_reg != '0);
        grant    = is_alloc && (count_reg == '0) && (fresh_reg < limit);
        exhaust  = is_alloc && (count_reg == '0) && !(fresh_reg < limit);
        dup      = s1_valid_reg && (s1_mode_reg == MODE_FREE) && in_heap && marked;
        push     = s1_valid_reg && (s1_mode_reg == MODE_FREE) && in_heap && !marked
                   && (count_reg < FULL);

        head_next  = pop  ? ((head_reg == LAST) ? '0 : head_reg + 1'b1) : head_reg;
        tail_next  = push ? ((tail_reg == LAST) ? '0 : tail_reg + 1'b1) : tail_reg;
        count_next = count_reg + QW'(push) - QW'(pop);
        fresh_next = fresh_reg + CNT_W'(grant);

        fresh_u = UW'(fresh_next);
        count_u = UW'(count_next);
        used    = (fresh_u <= count_u) ? '0 : CNT_W'(fresh_u - count_u);

        m_we    = clr_busy || push || pop;
        m_wdata = !clr_busy && push;
        m_raddr = AW'(in_fidx);
        if (clr_busy)
        begin
            m_waddr = clr_addr;
        end
        else if (push)
        begin
            m_waddr = AW'(s1_fidx_reg);
        end
        else
        begin
            m_waddr = AW'(q_head);
        end

        q_fwd_next = push && (tail_reg == head_next);
        m_fwd_next = m_we && (m_waddr == m_raddr);

        res.index      = pop ? q_head : (grant ? fresh_reg[IDX_W-1:0] : '0);
        res.status     = exhaust ? ST_EXHAUSTED : (dup ? ST_DUP : ST_OK);
        res.used_count = used;
    end

    assign res_valid = s1_valid_reg;

    ixa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (HEAP_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (push),
        .waddr (tail_reg),
        .wdata (s1_fidx_reg),
        .raddr (head_next),
        .rdata (q_rdata)
    );

    ixa_ram #(
        .WIDTH (1),
        .DEPTH (HEAP_DEPTH)
    ) u_mark_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            fresh_reg    <= '0;
            q_fwd_reg    <= 1'b0;
            m_fwd_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= acc;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            fresh_reg    <= fresh_next;
            q_fwd_reg    <= q_fwd_next;
            m_fwd_reg    <= m_fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_mode_reg <= in_mode;
            s1_fidx_reg <= in_fidx;
        end
        q_fwd_data_reg <= s1_fidx_reg;
        m_fwd_data_reg <= m_wdata;
    end
endmodule

// ===== rtl/index_allocator_free_fifo.sv =====
// Slot index allocator: an allocate item takes the oldest index waiting in the free queue,
// else the next never-used index below min(max_entries, HEAP_DEPTH), else reports
// exhaustion; a free item below HEAP_DEPTH queues its index unless already queued. Takes
// one item per cycle while the result buffer has room; each result is formed from the
// registered read of the queue and queued-mark memories, each with one write port used at
// most once per item. A three-entry result buffer lets input continue while results wait.
// After reset, req stays not ready while the queued-mark memory is cleared one entry a
// cycle; max_entries may be written at any idle time, including during that pass.
module index_allocator_free_fifo #(
    parameter int HEAP_DEPTH = ixa_pkg::HEAP_DEPTH_DEF
) (
    input logic       clk,
    input logic       rst_n,
    ixa_req_if.sink   req,
    ixa_res_if.source res,
    ixa_cfg_if.sink   cfg
);
    import ixa_pkg::*;

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(HEAP_DEPTH - 1);

    logic                  clr_busy_reg, clr_busy_next;
    logic [AW-1:0]         clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0]      max_entries_reg, max_entries_next;
    logic                  acc;
    logic                  s1_valid;
    result_t               s1_res, out_res;
    logic                  out_valid;
    logic [OUT_FILL_W-1:0] fill;

    assign cfg.ready      = 1'b1;
    assign req.ready      = !clr_busy_reg && ((32'(fill) + 32'(s1_valid)) < OUT_DEPTH);
    assign acc            = req.valid && req.ready;
    assign res.valid      = out_valid;
    assign res.index      = out_res.index;
    assign res.status     = out_res.status;
    assign res.used_count = out_res.used_count;

    always_comb
    begin
        clr_busy_next    = clr_busy_reg;
        clr_addr_next    = clr_addr_reg;
        max_entries_next = max_entries_reg;
        if (clr_busy_reg)
        begin
            if (clr_addr_reg == LAST)
            begin
                clr_busy_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
        if (cfg.valid && cfg.ready)
        begin
            max_entries_next = cfg.max_entries;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg    <= 1'b1;
            clr_addr_reg    <= '0;
            max_entries_reg <= MAX_ENTRIES_RST;
        end
        else
        begin
            clr_busy_reg    <= clr_busy_next;
            clr_addr_reg    <= clr_addr_next;
            max_entries_reg <= max_entries_next;
        end
    end

    ixa_core #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .acc         (acc),
        .in_mode     (req.mode),
        .in_fidx     (req.free_index),
        .max_entries (max_entries_reg),
        .clr_busy    (clr_busy_reg),
        .clr_addr    (clr_addr_reg),
        .res_valid   (s1_valid),
        .res         (s1_res)
    );

    ixa_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (s1_valid),
        .wr_data  (s1_res),
        .rd_valid (out_valid),
        .rd_ready (res.ready),
        .rd_data  (out_res),
        .fill     (fill)
    );
endmodule

// ===== rtl/ixa_checker.sv =====
module ixa_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      req_valid,
    input logic                      req_ready,
    input logic                      res_valid,
    input logic                      res_ready,
    input logic [ixa_pkg::IDX_W-1:0] res_index,
    input logic [ixa_pkg::ST_W-1:0]  res_status,
    input logic [ixa_pkg::CNT_W-1:0] res_used_count
);
    import ixa_pkg::*;

    logic [2:0] pend_reg, pend_next;

    always_comb
    begin
        pend_next = pend_reg + 3'(req_valid && req_ready) - 3'(res_valid && res_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // no result without an item in flight
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pend_reg != 3'd0)
        else $error("result without an accepted item");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_index)
            && $stable(res_status) && $stable(res_used_count))
        else $error("stalled result changed");

    // failed results carry index zero; free results do too, but this checks only failed ones
    a_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status == ST_EXHAUSTED || res_status == ST_DUP) |-> res_index == '0)
        else $error("nonzero index on a failed result");

    // mark memory clear runs right after reset
    a_clear_after_reset: assert property (@(posedge clk)
        rst_n && !$past(rst_n) |-> !req_ready)
        else $error("ready during clearing pass");
endmodule

bind index_allocator_free_fifo ixa_checker u_ixa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_index      (res.index),
    .res_status     (res.status),
    .res_used_count (res.used_count)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ixa_pkg::*;

    localparam int SLOT_COUNT = HEAP_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 200;
    localparam int REPORT_MAX = 10;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_LIMIT
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic             mode;
        logic [IDX_W-1:0] fidx;
        logic [CNT_W-1:0] limit;
        logic             pinned;
        logic [IDX_W-1:0] w_index;
        status_t          w_status;
        logic [CNT_W-1:0] w_used;
    } row_t;

    logic clk;
    logic rst_n;

    ixa_req_if req_bus ();
    ixa_res_if res_bus ();
    ixa_cfg_if cfg_bus ();

    index_allocator_free_fifo DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .res   (res_bus),
        .cfg   (cfg_bus)
    );

    // allocator image
    logic [IDX_W-1:0] model_queue [$];
    bit   [SLOT_COUNT-1:0] model_mark;
    int               model_fresh;
    logic [CNT_W-1:0] model_limit;

    result_t          pending_slots [$];
    logic [IDX_W-1:0] live_slots [$];
    result_t          got_res;
    result_t          want_res;
    logic             pin_on;
    result_t          pin_val;
    bit               rx_hold_req;
    int               burst_left;
    int               mismatch_count;
    int               cycle_count;

    row_t plan [26] = '{
        '{ROW_LIMIT, MODE_ALLOC, 10'd0,    11'd2,    1'b0, 10'd0,    ST_OK,        11'd0},
        '{ROW_ITEM,  MODE_ALLOC, 10'd0,    11'd0,    1'b1, 10'd0,    ST_OK,        11'd1},
        '{ROW_ITEM,  MODE_ALLOC, 10'd1023, 11'd0,    1'b1, 10'd1,    ST_OK,        11'd2},
        '{ROW_ITEM,  MODE_ALLOC, 10'd0,    11'd0,    1'b1, 10'd0,    ST_EXHAUSTED, 11'd2},
        '{ROW_ITEM,  MODE_FREE,  10'd1023, 11'd0,    1'b1, 10'd0,    ST_OK,        11'd1},
        '{ROW_ITEM,  MODE_FREE,  10'd1023, 11'd0,    1'b1, 10'd0,    ST_DUP,       11'd1},
        '{ROW_ITEM,  MODE_FREE,  10'd0,    11'd0,    1'b1, 10'd0,    ST_OK,        11'd0},
        '{ROW_ITEM,  MODE_FREE,  10'd1,    11'd0,    1'b1, 10'd0,    ST_OK,        11'd0},
        '{ROW_ITEM,  MODE_ALLOC, 10'd0,    11'd0,    1'b1, 10'd1023, ST_OK,        11'd0},
        '{ROW_ITEM,  MODE_ALLOC, 10'd0,    11'd0,    1'b1, 10'd0,    ST_OK,        11'd1},
        '{ROW_ITEM,  MODE_ALLOC, 10'd0,    11'd0,    1'b1, 10'd1,    ST_OK,        11'd2},
        '{ROW_ITEM,  MODE_ALLOC, 10'd0,    11'd0,    1'b1, 10'd0,    ST_EXHAUSTED, 11'd2},
        '{ROW_LIMIT, MODE_ALLOC, 10'd0,    11'd0,    1'b0, 10'd0,    ST_OK,        11'd0},
        '{ROW_ITEM,  MODE_ALLOC, 10'd0,    11'd0,    1'b1, 10'd0,    ST_EXHAUSTED, 11'd2},
        '{ROW_ITEM,  MODE_FREE,  10'd5,    11'd0,    1'b1, 10'd0,    ST_OK,        11'd1},
        '{ROW_ITEM,  MODE_ALLOC, 10'd0,    11'd0,    1'b1, 10'd5,    ST_OK,        11'd2},
        '{ROW_LIMIT, MODE_ALLOC, 10'd0,    11'd2047, 1'b0, 10'd0,    ST_OK,        11'd0},
        '{ROW_ITEM,  MODE_ALLOC, 10'd682,  11'd0,    1'b0, 10'd0,    ST_OK,        11'd0},
        '{ROW_ITEM,  MODE_FREE,  10'd1023, 11'd0,    1'b0, 10'd0,    ST_OK,        11'd0},
        '{ROW_ITEM,  MODE_FREE,  10'd1023, 11'd0,    1'b0, 10'd0,    ST_OK,        11'd0},
        '{ROW_ITEM,  MODE_FREE,  10'd512,  11'd0,    1'b0, 10'd0,    ST_OK,        11'd0},
        '{ROW_ITEM,  MODE_FREE,  10'd341,  11'd0,    1'b0, 10'd0,    ST_OK,        11'd0},
        '{ROW_ITEM,  MODE_ALLOC, 10'd0,    11'd0,    1'b0, 10'd0,    ST_OK,        11'd0},
        '{ROW_ITEM,  MODE_ALLOC, 10'd0,    11'd0,    1'b0, 10'd0,    ST_OK,        11'd0},
        '{ROW_ITEM,  MODE_ALLOC, 10'd0,    11'd0,    1'b0, 10'd0,    ST_OK,        11'd0},
        '{ROW_ITEM,  MODE_ALLOC, 10'd0,    11'd0,    1'b0, 10'd0,    ST_OK,        11'd0}
    };

    function automatic result_t next_slot_result(input logic m, input logic [IDX_W-1:0] fi);
        result_t r;
        int      lim;
        r = '0;
        r.status = ST_OK;
        lim = (int'(model_limit) > SLOT_COUNT) ? SLOT_COUNT : int'(model_limit);
        if (m == MODE_ALLOC)
        begin
            if (model_queue.size() != 0)
            begin
                r.index = model_queue[0];
                model_queue.delete(0);
                model_mark[r.index] = 1'b0;
            end
            else if (model_fresh < lim)
            begin
                r.index = IDX_W'(model_fresh);
                model_fresh++;
            end
            else
            begin
                r.status = ST_EXHAUSTED;
            end
        end
        else if (int'(fi) < SLOT_COUNT)
        begin
            if (model_mark[fi])
            begin
                r.status = ST_DUP;
            end
            else
            begin
                model_queue = {model_queue, fi};
                model_mark[fi] = 1'b1;
            end
        end
        if (model_fresh > model_queue.size())
            r.used_count = CNT_W'(model_fresh - model_queue.size());
        else
            r.used_count = '0;
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench: errors");
        $finish;
    end

    // predictor follows every accepted write and item
    initial
    begin
        model_mark = '0;
        model_fresh = 0;
        model_limit = MAX_ENTRIES_RST;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1)
            model_limit = cfg_bus.max_entries;
        if (rst_n === 1'b1 && req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
        begin
            got_res = next_slot_result(req_bus.mode, req_bus.free_index);
            if (req_bus.mode == MODE_ALLOC && got_res.status == ST_OK)
                live_slots = {live_slots, got_res.index};
            pending_slots = {pending_slots, (pin_on ? pin_val : got_res)};
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
        begin
            if (pending_slots.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result: index %0d status %0d used %0d",
                             res_bus.index, res_bus.status, res_bus.used_count);
            end
            else
            begin
                want_res = pending_slots[0];
                pending_slots.delete(0);
                if (res_bus.index !== want_res.index
                    || res_bus.status !== want_res.status
                    || res_bus.used_count !== want_res.used_count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display({"mismatch: expected index %0d status %0d used %0d,",
                                  " got index %0d status %0d used %0d"},
                                 want_res.index, want_res.status, want_res.used_count,
                                 res_bus.index, res_bus.status, res_bus.used_count);
                end
            end
        end
    end

    // result side stall pattern, with one long hold in the squeeze phase
    initial
    begin
        int style;
        int style_left;
        int hold_left;
        res_bus.ready = 1'b0;
        style = 0;
        style_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (style_left == 0)
            begin
                style = $urandom_range(3, 0);
                style_left = $urandom_range(300, 40);
            end
            style_left--;
            if (hold_left != 0)
            begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end
            else
            begin
                case (style)
                    0: res_bus.ready <= 1'b1;
                    1: res_bus.ready <= ($urandom_range(3, 0) != 0);
                    2: res_bus.ready <= ($urandom_range(3, 0) == 0);
                    default: res_bus.ready <= (style_left % 3 != 0);
                endcase
            end
        end
    end

    task automatic offer_item(input logic m, input logic [IDX_W-1:0] fi, input logic pin,
                              input result_t want);
        req_bus.valid <= 1'b1;
        req_bus.mode <= m;
        req_bus.free_index <= fi;
        pin_on <= pin;
        pin_val <= want;
        @(posedge clk);
        while (req_bus.ready !== 1'b1)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_slots.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [CNT_W-1:0] v);
        cfg_bus.valid <= 1'b1;
        cfg_bus.max_entries <= v;
        @(posedge clk);
        while (cfg_bus.ready !== 1'b1)
            @(posedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // allocate at alloc_pct percent, else give back held slots, with some stray frees
    task automatic run_phase(input logic [CNT_W-1:0] lim, input int items, input int alloc_pct,
                             input bit squeeze);
        int               roll;
        int               pick;
        int               gap;
        logic [IDX_W-1:0] fi;
        wait_drained();
        write_limit(lim);
        for (int n = 0; n < items; n++)
        begin
            if (squeeze && n == items / 2)
            begin
                rx_hold_req = 1'b1;
                burst_left = 24;
            end
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(40, 1);
                gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
                if (gap != 0)
                begin
                    req_bus.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            roll = $urandom_range(99, 0);
            if (roll < alloc_pct)
            begin
                offer_item(MODE_ALLOC, IDX_W'($urandom), 1'b0, '0);
            end
            else if (live_slots.size() != 0 && roll % 8 != 0)
            begin
                pick = $urandom_range(live_slots.size() - 1, 0);
                fi = live_slots[pick];
                live_slots.delete(pick);
                offer_item(MODE_FREE, fi, 1'b0, '0);
            end
            else
            begin
                offer_item(MODE_FREE, IDX_W'($urandom), 1'b0, '0);
            end
        end
    endtask

    initial
    begin
        result_t want;
        rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.mode = MODE_ALLOC;
        req_bus.free_index = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.max_entries = MAX_ENTRIES_RST;
        pin_on = 1'b0;
        pin_val = '0;
        rx_hold_req = 1'b0;
        burst_left = 0;
        mismatch_count = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[r])
        begin
            if (plan[r].kind == ROW_LIMIT)
            begin
                wait_drained();
                write_limit(plan[r].limit);
            end
            else
            begin
                want.index = plan[r].w_index;
                want.status = plan[r].w_status;
                want.used_count = plan[r].w_used;
                offer_item(plan[r].mode, plan[r].fidx, plan[r].pinned, want);
            end
        end

        run_phase(11'd20, 150, 55, 1'b0);
        run_phase(11'd1, 80, 50, 1'b0);
        run_phase(11'd0, 60, 50, 1'b0);
        run_phase(11'd2047, 820, 96, 1'b1);
        run_phase(11'd1024, 300, 98, 1'b0);

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_slots.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
